@@ rtl/core/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared widths, codes and types of the request rate pacer.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int COUNT_W   = 16;
  localparam int TIME_W    = 63;
  localparam int SLOT_W    = 64;
  localparam int WHOLE_W   = 36;
  localparam int FRAC_BITS = 20;
  localparam longint unsigned FRAC_SCALE = 64'd1 << FRAC_BITS;
  localparam int FPROD_W   = FRAC_BITS + COUNT_W;
  localparam int WPROD_W   = WHOLE_W + COUNT_W;
  localparam int K_W       = WPROD_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WHOLE_W;
  localparam int OUTCOME_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_WHOLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_FRAC  = 2'd1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_NOW     = 2'd0,
    OUTCOME_DELAYED = 2'd1,
    OUTCOME_CANCEL  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [K_W-1:0]       k;
    logic [FRAC_BITS-1:0] frac_lo;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    limit;
  } work_t;

endpackage

@@ rtl/core/rrp_front.sv @@
// ----------------------------------------------------------------------------
// rrp_front
// Accepts requests, holds the interval registers and forms the token products.
// ----------------------------------------------------------------------------
module rrp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrp_pkg::COUNT_W-1:0]   token_count,
  input  logic [rrp_pkg::TIME_W-1:0]    now_ns,
  input  logic [rrp_pkg::TIME_W-1:0]    max_delay_ns,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          push,
  input  logic                          push_ready,
  output rrp_pkg::work_t                push_item
);
  import rrp_pkg::*;

  logic [WHOLE_W-1:0]   interval_whole;
  logic [FRAC_BITS-1:0] interval_frac;

  logic                 stage_valid;
  logic                 stage_valid_next;
  logic [WPROD_W-1:0]   whole_prod;
  logic [FPROD_W-1:0]   frac_prod;
  logic [TIME_W-1:0]    stage_now;
  logic [TIME_W-1:0]    stage_limit;
  logic                 accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_whole <= '0;
      interval_frac  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INTERVAL_WHOLE: interval_whole <= cfg_data;
        CFG_INTERVAL_FRAC:  interval_frac  <= cfg_data[FRAC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = stage_valid && !push_ready;
  assign accept   = in_valid && !in_stall;
  assign push     = stage_valid && push_ready;

  always_comb begin
    stage_valid_next = stage_valid;
    if (accept) begin
      stage_valid_next = 1'b1;
    end else if (push) begin
      stage_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      whole_prod  <= WPROD_W'(interval_whole) * WPROD_W'(token_count);
      frac_prod   <= FPROD_W'(interval_frac) * FPROD_W'(token_count);
      stage_now   <= now_ns;
      stage_limit <= max_delay_ns;
    end
  end

  always_comb begin
    push_item.k       = K_W'(whole_prod) + K_W'(frac_prod[FPROD_W-1:FRAC_BITS]);
    push_item.frac_lo = frac_prod[FRAC_BITS-1:0];
    push_item.now     = stage_now;
    push_item.limit   = stage_limit;
  end

endmodule

@@ rtl/core/rrp_queue.sv @@
// ----------------------------------------------------------------------------
// rrp_queue
// Short queue of prepared requests between the front and the back.
// ----------------------------------------------------------------------------
module rrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  rrp_pkg::work_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output rrp_pkg::work_t pop_item
);
  import rrp_pkg::*;

  work_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/rrp_back.sv @@
// ----------------------------------------------------------------------------
// rrp_back
// Holds the slot state, decides each request and registers the result.
// ----------------------------------------------------------------------------
module rrp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop,
  input  rrp_pkg::work_t                pop_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrp_pkg::OUTCOME_W-1:0] outcome,
  output logic [rrp_pkg::TIME_W-1:0]    delay_ns
);
  import rrp_pkg::*;

  logic [SLOT_W-1:0]    slot_whole;
  logic [FRAC_BITS-1:0] slot_frac;
  logic [FRAC_BITS:0]   frac_sum;
  logic [SLOT_W:0]      whole_sum;
  logic [SLOT_W-1:0]    next_whole;
  logic [SLOT_W:0]      diff;
  logic [SLOT_W-1:0]    wait_ns;
  logic                 due;
  logic                 fits;
  outcome_t             decision;

  assign pop = pop_valid && (!out_valid || !out_stall);

  always_comb begin
    frac_sum   = {1'b0, slot_frac} + {1'b0, pop_item.frac_lo};
    whole_sum  = {1'b0, slot_whole} + (SLOT_W + 1)'(pop_item.k)
                 + (SLOT_W + 1)'(frac_sum[FRAC_BITS]);
    next_whole = whole_sum[SLOT_W] ? '1 : whole_sum[SLOT_W-1:0];
    diff       = {1'b0, next_whole} - {2'b00, pop_item.now};
    wait_ns    = diff[SLOT_W-1:0];
    due        = diff[SLOT_W] || (diff == '0);
    fits       = wait_ns < {1'b0, pop_item.limit};
    if (due) begin
      decision = OUTCOME_NOW;
    end else if (fits) begin
      decision = OUTCOME_DELAYED;
    end else begin
      decision = OUTCOME_CANCEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_whole <= '0;
      slot_frac  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        case (decision)
          OUTCOME_NOW: begin
            slot_whole <= {1'b0, pop_item.now};
            slot_frac  <= '0;
          end
          OUTCOME_DELAYED: begin
            slot_whole <= next_whole;
            slot_frac  <= frac_sum[FRAC_BITS-1:0];
          end
          default: begin
          end
        endcase
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome  <= decision;
      delay_ns <= (decision == OUTCOME_DELAYED) ? wait_ns[TIME_W-1:0] : '0;
    end
  end

  a_due_sets_slot: assert property (@(posedge clk) disable iff (rst)
    pop && decision == OUTCOME_NOW |=> slot_whole == {1'b0, $past(pop_item.now)}
      && slot_frac == '0)
    else $error("slot not moved to current time on an immediate grant");

  a_cancel_keeps_slot: assert property (@(posedge clk) disable iff (rst)
    pop && decision == OUTCOME_CANCEL |=> $stable(slot_whole) && $stable(slot_frac))
    else $error("slot changed on a cancelled request");

  a_delay_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUTCOME_DELAYED |-> delay_ns != '0)
    else $error("delayed grant carries no wait");

  a_delay_only_when_delayed: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUTCOME_DELAYED |-> delay_ns == '0)
    else $error("wait reported on a result without delay");

endmodule

@@ rtl/core/request_rate_pacer.sv @@
// ----------------------------------------------------------------------------
// request_rate_pacer
// Virtual scheduling rate pacer with a fractional per-token interval.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  token_count, now_ns, max_delay_ns
// out       output     out_valid/out_stall  outcome, delay_ns
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle is sustained while the output is not stalled; the
// slot update loop closes within the back part. A request passes the front
// stage register, the queue and the output register to the result. Reset
// clears the slot state and the interval registers. An output stall fills
// the queue and then the input stage before the input channel stalls.
// ----------------------------------------------------------------------------
module request_rate_pacer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rrp_pkg::COUNT_W-1:0]    token_count,
  input  logic [rrp_pkg::TIME_W-1:0]     now_ns,
  input  logic [rrp_pkg::TIME_W-1:0]     max_delay_ns,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rrp_pkg::OUTCOME_W-1:0]  outcome,
  output logic [rrp_pkg::TIME_W-1:0]     delay_ns,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rrp_pkg::*;

  logic  push;
  logic  push_ready;
  work_t push_item;
  logic  pop_valid;
  logic  pop;
  work_t pop_item;

  rrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .token_count  (token_count),
    .now_ns       (now_ns),
    .max_delay_ns (max_delay_ns),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  rrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  rrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .outcome   (outcome),
    .delay_ns  (delay_ns)
  );

endmodule
